// ----- sv/mft_pkg.sv -----
package mft_pkg;

  localparam int POS_W     = 11;
  localparam int VAL_W     = 30;
  localparam int MOD_W     = 31;
  localparam int OP_W      = 2;
  localparam int ST_W      = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [POS_W-1:0] SIZE_RESET = 11'd1024;
  localparam logic [MOD_W-1:0] MOD_RESET  = 31'd1000000007;
  localparam logic [MOD_W-1:0] MOD_MIN    = 31'd2;
  localparam logic [MOD_W-1:0] MOD_MAX    = 31'h4000_0000;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } mft_op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_BAD_VAL = 2'd2
  } mft_status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TREE_SIZE = 1'b0,
    CFG_MODULUS   = 1'b1
  } mft_cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] add_value;
  } mft_in_t;

  typedef struct packed {
    logic [VAL_W-1:0] prefix_sum;
    logic [ST_W-1:0]  status;
  } mft_out_t;

  typedef struct packed {
    logic load;
    logic walk_add;
    logic walk_qry;
    logic clr_load;
    logic clr_step;
  } mft_cmd_t;

  typedef struct packed {
    logic pos_zero;
    logic pos_over;
    logic val_over;
    logic add_done;
    logic qry_done;
    logic clr_last;
  } mft_sts_t;

  function automatic logic [VAL_W-1:0] mod_add(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b,
                                               input logic [MOD_W-1:0] m);
    logic [MOD_W-1:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= m) begin
      s = s - m;
    end
    return s[VAL_W-1:0];
  endfunction

endpackage

// ----- sv/mft_datapath.sv -----
module mft_datapath #(
  parameter int MAX_POSITIONS = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mft_pkg::mft_cmd_t                 cmd,
  output mft_pkg::mft_sts_t                 sts,
  input  logic [mft_pkg::POS_W-1:0]         position,
  input  logic [mft_pkg::VAL_W-1:0]         add_value,
  input  logic                              cfg_wr,
  input  logic [mft_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mft_pkg::MOD_W-1:0]         cfg_data,
  output logic [mft_pkg::VAL_W-1:0]         acc
);

  localparam int PW = mft_pkg::POS_W;
  localparam int IW = mft_pkg::POS_W + 1;
  localparam int VW = mft_pkg::VAL_W;
  localparam int MW = mft_pkg::MOD_W;
  localparam int AW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
  localparam int SIZE_CAP_I = (MAX_POSITIONS > (2**PW - 1)) ? (2**PW - 1) : MAX_POSITIONS;
  localparam logic [PW-1:0] SIZE_CAP  = PW'(SIZE_CAP_I);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_POSITIONS - 1);

  logic [PW-1:0] tree_size_r;
  logic [MW-1:0] modulus_r;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] pnode_r;
  logic          pend_r;
  logic [VW-1:0] acc_r, acc_nxt;
  logic [VW-1:0] val_r;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [VW-1:0] rdata_r;
  logic [VW-1:0] mem [MAX_POSITIONS];

  logic [PW-1:0] size_eff;
  logic [MW-1:0] mod_eff;
  logic [IW-1:0] lowbit;
  logic          issue_add, issue_qry, issue;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  logic [VW-1:0] wr_data;

  assign size_eff = (tree_size_r > SIZE_CAP) ? SIZE_CAP : tree_size_r;
  assign mod_eff  = (modulus_r < mft_pkg::MOD_MIN) ? mft_pkg::MOD_MIN :
                    (modulus_r > mft_pkg::MOD_MAX) ? mft_pkg::MOD_MAX : modulus_r;

  assign lowbit    = idx_r & (~idx_r + IW'(1));
  assign issue_add = cmd.walk_add && (idx_r <= {1'b0, size_eff});
  assign issue_qry = cmd.walk_qry && (idx_r != '0);
  assign issue     = issue_add || issue_qry;

  assign rd_addr = AW'(idx_r - IW'(1));
  assign wr_en   = cmd.clr_step || (cmd.walk_add && pend_r);
  assign wr_addr = cmd.clr_step ? clr_cnt_r : AW'(pnode_r - IW'(1));
  assign wr_data = cmd.clr_step ? '0 : mft_pkg::mod_add(rdata_r, val_r, mod_eff);

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.load) begin
      idx_nxt = {1'b0, position};
    end else if (issue_add) begin
      idx_nxt = idx_r + lowbit;
    end else if (issue_qry) begin
      idx_nxt = idx_r - lowbit;
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.load) begin
      acc_nxt = '0;
    end else if (cmd.walk_qry && pend_r) begin
      acc_nxt = mft_pkg::mod_add(acc_r, rdata_r, mod_eff);
    end
  end

  always_comb begin
    clr_cnt_nxt = clr_cnt_r;
    if (cmd.clr_load) begin
      clr_cnt_nxt = '0;
    end else if (cmd.clr_step) begin
      clr_cnt_nxt = clr_cnt_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tree_size_r <= mft_pkg::SIZE_RESET;
      modulus_r   <= mft_pkg::MOD_RESET;
      pend_r      <= 1'b0;
      clr_cnt_r   <= '0;
    end else begin
      if (cfg_wr) begin
        if (cfg_index == mft_pkg::CFG_TREE_SIZE) begin
          tree_size_r <= cfg_data[PW-1:0];
        end else begin
          modulus_r <= cfg_data;
        end
      end
      pend_r    <= issue && !cmd.load;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    acc_r <= acc_nxt;
    if (issue) begin
      pnode_r <= idx_r;
    end
    if (cmd.load) begin
      val_r <= add_value;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign sts.pos_zero = (position == '0);
  assign sts.pos_over = (position > size_eff);
  assign sts.val_over = ({1'b0, add_value} >= mod_eff);
  assign sts.add_done = !pend_r && (idx_r > {1'b0, size_eff});
  assign sts.qry_done = !pend_r && (idx_r == '0);
  assign sts.clr_last = (clr_cnt_r == LAST_ADDR);
  assign acc          = acc_r;

endmodule

// ----- sv/mft_ctrl.sv -----
module mft_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [mft_pkg::OP_W-1:0]   in_op,
  output logic                       out_valid,
  input  logic                       out_ready,
  output mft_pkg::mft_out_t          out_data,
  output mft_pkg::mft_cmd_t          cmd,
  input  mft_pkg::mft_sts_t          sts,
  input  logic [mft_pkg::VAL_W-1:0]  acc
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CLR,
    S_ADD,
    S_QRY,
    S_DONE
  } state_t;

  state_t                     state_r, state_nxt;
  logic                       out_valid_r, out_valid_nxt;
  mft_pkg::mft_out_t          out_data_r, out_data_nxt;
  logic [mft_pkg::ST_W-1:0]   res_status_r, res_status_nxt;
  logic                       res_acc_r, res_acc_nxt;
  logic                       accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    res_status_nxt = res_status_r;
    res_acc_nxt    = res_acc_r;
    cmd            = '0;
    case (state_r)
      S_INIT: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          res_status_nxt = mft_pkg::ST_OK;
          res_acc_nxt    = 1'b0;
          state_nxt      = S_DONE;
          case (in_op)
            mft_pkg::OP_ADD: begin
              if (sts.pos_zero || sts.pos_over) begin
                res_status_nxt = mft_pkg::ST_BAD_POS;
              end else if (sts.val_over) begin
                res_status_nxt = mft_pkg::ST_BAD_VAL;
              end else begin
                cmd.load  = 1'b1;
                state_nxt = S_ADD;
              end
            end
            mft_pkg::OP_QUERY: begin
              if (sts.pos_over) begin
                res_status_nxt = mft_pkg::ST_BAD_POS;
              end else begin
                cmd.load    = 1'b1;
                res_acc_nxt = 1'b1;
                state_nxt   = S_QRY;
              end
            end
            mft_pkg::OP_CLEAR: begin
              cmd.clr_load = 1'b1;
              state_nxt    = S_CLR;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_DONE;
        end
      end
      S_ADD: begin
        cmd.walk_add = 1'b1;
        if (sts.add_done) begin
          state_nxt = S_DONE;
        end
      end
      S_QRY: begin
        cmd.walk_qry = 1'b1;
        if (sts.qry_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.prefix_sum = res_acc_r ? acc : '0;
          out_data_nxt.status     = res_status_r;
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      out_valid_r  <= 1'b0;
      res_status_r <= mft_pkg::ST_OK;
      res_acc_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      res_status_r <= res_status_nxt;
      res_acc_r    <= res_acc_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- sv/modular_fenwick_tree.sv -----
// channel  direction  handshake            payload
// in_      input      in_valid/in_ready    mft_in_t: operation, position, add_value
// out_     output     out_valid/out_ready  mft_out_t: prefix_sum, status
// cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data (tree_size, modulus)
//
// one item at a time; add and query walk the tree nodes along the index path of the position,
// with one tree store read and one write per cycle along the index walk
// clear and the pass after reset zero every store entry, one store entry per cycle
// no item is taken during the pass after reset; configuration writes are always taken
// the next item is taken while a result waits in the output register
module modular_fenwick_tree #(
  parameter int MAX_POSITIONS = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  mft_pkg::mft_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output mft_pkg::mft_out_t                 out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mft_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mft_pkg::MOD_W-1:0]         cfg_data
);

  mft_pkg::mft_cmd_t         cmd;
  mft_pkg::mft_sts_t         sts;
  logic [mft_pkg::VAL_W-1:0] acc;

  assign cfg_ready = 1'b1;

  mft_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_data.operation),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts),
    .acc       (acc)
  );

  mft_datapath #(
    .MAX_POSITIONS (MAX_POSITIONS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .position  (in_data.position),
    .add_value (in_data.add_value),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .acc       (acc)
  );

`ifndef SYNTHESIS
  a_busy_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_ready)
    else $error("item taken during store clearing pass");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while one is in progress");

  a_sum_only_when_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.prefix_sum != '0)) |-> (out_data.status == mft_pkg::ST_OK))
    else $error("nonzero sum with error status");
`endif

endmodule
